>>> hw/rtl/fsc_pkg.sv
`timescale 1ns / 1ps
// fan speed controller shared types, constants and curve tables
package fsc_pkg;

  localparam int TEMP_W = 8;
  localparam int STOP_W = 7;
  localparam int PWM_W  = 8;
  localparam int BY_W   = 3;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  typedef enum logic [2:0] {
    MODE_SILENT = 3'd0, MODE_NORMAL = 3'd1, MODE_AGGR = 3'd2, MODE_AUTO = 3'd3,
    MODE_FULL = 3'd4, MODE_CUSTOM = 3'd5, MODE_PID = 3'd6, MODE_OFF = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    BY_DISABLED = 3'd0, BY_OVERRIDE = 3'd1, BY_HELD = 3'd2, BY_SAFETY = 3'd3,
    BY_FULL = 3'd4, BY_PID = 3'd5, BY_CURVE = 3'd6
  } by_t;

  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET = 3'd1;
  localparam logic [IDX_W-1:0] REG_GP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_GI     = 3'd3;
  localparam logic [IDX_W-1:0] REG_GD     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CTEMP  = 3'd5;
  localparam logic [IDX_W-1:0] REG_CPWM   = 3'd6;

  localparam logic [7:0] PWM_MAX     = 8'd255;
  localparam int         SAFE_MARGIN = 3;

  function automatic logic [7:0] normal_lut(input logic [5:0] k);
    logic [7:0] v;
    case (k)
      6'd0: v = 8'd60;   6'd1: v = 8'd61;   6'd2: v = 8'd63;   6'd3: v = 8'd66;
      6'd4: v = 8'd68;   6'd5: v = 8'd71;   6'd6: v = 8'd74;   6'd7: v = 8'd77;
      6'd8: v = 8'd80;   6'd9: v = 8'd83;   6'd10: v = 8'd86;  6'd11: v = 8'd89;
      6'd12: v = 8'd92;  6'd13: v = 8'd96;  6'd14: v = 8'd99;  6'd15: v = 8'd102;
      6'd16: v = 8'd106; 6'd17: v = 8'd109; 6'd18: v = 8'd113; 6'd19: v = 8'd116;
      6'd20: v = 8'd120; 6'd21: v = 8'd124; 6'd22: v = 8'd127; 6'd23: v = 8'd131;
      6'd24: v = 8'd135; 6'd25: v = 8'd139; 6'd26: v = 8'd142; 6'd27: v = 8'd146;
      6'd28: v = 8'd150; 6'd29: v = 8'd154; 6'd30: v = 8'd158; 6'd31: v = 8'd162;
      6'd32: v = 8'd166; 6'd33: v = 8'd170; 6'd34: v = 8'd174; 6'd35: v = 8'd178;
      6'd36: v = 8'd182; 6'd37: v = 8'd186; 6'd38: v = 8'd190; 6'd39: v = 8'd194;
      6'd40: v = 8'd198; 6'd41: v = 8'd203; 6'd42: v = 8'd207; 6'd43: v = 8'd211;
      6'd44: v = 8'd215; 6'd45: v = 8'd220;
      default: v = 8'd220;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] aggr_lut(input logic [5:0] k);
    logic [7:0] v;
    case (k)
      6'd0: v = 8'd80;   6'd1: v = 8'd80;   6'd2: v = 8'd80;   6'd3: v = 8'd81;
      6'd4: v = 8'd82;   6'd5: v = 8'd84;   6'd6: v = 8'd85;   6'd7: v = 8'd87;
      6'd8: v = 8'd89;   6'd9: v = 8'd91;   6'd10: v = 8'd94;  6'd11: v = 8'd97;
      6'd12: v = 8'd100; 6'd13: v = 8'd103; 6'd14: v = 8'd106; 6'd15: v = 8'd109;
      6'd16: v = 8'd113; 6'd17: v = 8'd117; 6'd18: v = 8'd121; 6'd19: v = 8'd125;
      6'd20: v = 8'd130; 6'd21: v = 8'd134; 6'd22: v = 8'd139; 6'd23: v = 8'd144;
      6'd24: v = 8'd149; 6'd25: v = 8'd155; 6'd26: v = 8'd160; 6'd27: v = 8'd166;
      6'd28: v = 8'd172; 6'd29: v = 8'd178; 6'd30: v = 8'd184; 6'd31: v = 8'd190;
      6'd32: v = 8'd197; 6'd33: v = 8'd203; 6'd34: v = 8'd210; 6'd35: v = 8'd217;
      6'd36: v = 8'd224; 6'd37: v = 8'd232; 6'd38: v = 8'd239; 6'd39: v = 8'd247;
      6'd40: v = 8'd255;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/fan_speed_controller.sv
`timescale 1ns / 1ps
// fan speed controller top level: priority rules, pid and curve sequencer
// sequencing: decisions without arithmetic and table curves go S_DECIDE to S_OUT;
//   pid adds S_MP, S_MI, S_MD and S_PIDEND; silent, auto and custom curves add
//   S_LIN_MUL, S_DIV (16-step restoring divider) and S_DIVEND
// throughput: one transaction at a time; ready drops from accept until the
//   result moves into the output register; a stalled result does not hold back
//   acceptance of the next input, though its result then waits in S_OUT
// reset: synchronous active-low rst_n restores register defaults and clears
//   pid state, last pwm and the output valid
module fan_speed_controller #(
  parameter int INTEGRAL_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [7:0] temperature, [14:8] stop_threshold, [15] force_full
  input  logic [15:0]               in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [7:0] pwm, [10:8] decided_by, rest zero
  output logic [15:0]               out_tdata,
  input  logic                      cfg_we,
  input  logic [fsc_pkg::IDX_W-1:0] cfg_index,
  input  logic [fsc_pkg::CFG_W-1:0] cfg_data
);
  import fsc_pkg::*;

  localparam int IB  = INTEGRAL_BITS;
  localparam int MW  = IB + 18;         // product width (signed operand x 17-bit gain)
  localparam int AW  = MW + 2;          // accumulator width for three terms

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_MP, S_MI, S_MD, S_PIDEND, S_LIN_MUL, S_DIV, S_DIVEND, S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [2:0]  mode_r;
  logic [6:0]  target_r;
  logic [15:0] gp_r, gi_r, gd_r, ctemp_r, cpwm_r;

  // controller state
  logic [7:0]           last_pwm_r;
  logic signed [IB-1:0] isum_r;
  logic signed [8:0]    prev_err_r;
  logic                 primed_r;

  // transaction being worked
  logic signed [7:0] temp_r;
  logic [6:0]        stop_r;
  logic              force_r;

  // pid working registers
  logic signed [8:0]    err_r;
  logic signed [IB-1:0] inew_r;
  logic signed [AW-1:0] acc_r;

  // linear curve working registers
  logic [7:0]  pmin_r;
  logic [15:0] num_r;   // (t-tmin)*(pmax-pmin), divided in place
  logic [15:0] rem_r;
  logic [8:0]  den_r;
  logic [4:0]  cnt_r;

  // output
  logic        ovalid_r;
  logic [7:0]  opwm_r;
  logic [2:0]  oby_r;
  logic [7:0]  res_pwm_r;
  logic [2:0]  res_by_r;

  // the output register parts the two sides, so input only waits on the sequencer
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, oby_r, opwm_r};

  // shared multiplier: signed operand times unsigned 16-bit gain
  logic signed [IB-1:0] mul_a;
  logic        [15:0]   mul_b;
  logic signed [MW-1:0] mul_p;
  assign mul_p = MW'(mul_a) * $signed({1'b0, mul_b});

  // priority decision
  logic signed [8:0] t9, stop_m;
  assign t9     = 9'(temp_r);
  assign stop_m = $signed({2'b0, stop_r}) - 9'(SAFE_MARGIN);

  // pid terms
  logic signed [8:0]    err_c;
  logic signed [IB:0]   isum_raw;
  logic signed [IB-1:0] isum_sat;
  logic signed [IB-1:0] imax, imin;
  assign err_c    = t9 - $signed({2'b0, target_r});
  assign isum_raw = (IB+1)'(isum_r) + (IB+1)'(err_r);
  assign imax     = {1'b0, {(IB-1){1'b1}}};
  assign imin     = {1'b1, {(IB-1){1'b0}}};
  always_comb begin
    if (isum_raw > (IB+1)'(imax))      isum_sat = imax;
    else if (isum_raw < (IB+1)'(imin)) isum_sat = imin;
    else                               isum_sat = isum_raw[IB-1:0];
  end

  // curve parameters for the current mode
  logic [7:0] c_tmin, c_tmax, c_pmin, c_pmax, t_cl;
  logic [5:0] k_idx;
  always_comb begin
    c_tmin = 8'd25; c_tmax = 8'd70; c_pmin = 8'd50; c_pmax = 8'd200;
    case (mode_r)
      MODE_SILENT: begin c_tmax = 8'd50; c_pmin = 8'd30; c_pmax = 8'd120; end
      MODE_CUSTOM: begin
        c_tmin = ctemp_r[7:0];
        c_tmax = (ctemp_r[15:8] <= ctemp_r[7:0]) ? ctemp_r[7:0] + 8'd1 : ctemp_r[15:8];
        c_pmin = cpwm_r[7:0];
        c_pmax = (cpwm_r[15:8] < cpwm_r[7:0]) ? cpwm_r[7:0] : cpwm_r[15:8];
      end
      MODE_AGGR:   c_tmax = 8'd65;
      default: ;
    endcase
  end
  // tmin may be 255 so tmax may be 256 in the custom case
  logic [8:0] tmax9;
  assign tmax9 = (mode_r == MODE_CUSTOM && ctemp_r[15:8] <= ctemp_r[7:0])
                 ? {1'b0, ctemp_r[7:0]} + 9'd1 : {1'b0, c_tmax};
  logic signed [9:0] tcl10;
  always_comb begin
    if (temp_r[7] || {1'b0, temp_r} < {1'b0, c_tmin}) tcl10 = $signed({2'b0, c_tmin});
    else if ({1'b0, temp_r} > tmax9)                    tcl10 = $signed({1'b0, tmax9});
    else                                                tcl10 = $signed({2'b0, temp_r});
  end
  assign t_cl  = tcl10[7:0];
  assign k_idx = 6'(t_cl - 8'd25);

  // silent: m = 50 - t; uses num = 90*(625-m*m), den 625 handled by divider
  logic [5:0]  sil_m;
  logic [15:0] lin_num;
  assign sil_m = 6'(8'd50 - t_cl);
  always_comb begin
    if (mode_r == MODE_SILENT)
      lin_num = 16'(16'd90 * (16'd625 - 16'(sil_m) * 16'(sil_m)));
    else
      lin_num = 16'(9'(tcl10[8:0] - 9'(c_tmin))) * 16'(c_pmax - c_pmin);
  end

  // divider step
  logic [16:0] rem_sh;
  assign rem_sh = {rem_r, num_r[15]};

  always_comb begin
    mul_a = IB'(err_r);
    mul_b = gp_r;
    case (state_r)
      S_MI: begin mul_a = isum_sat; mul_b = gi_r; end
      S_MD: begin mul_a = IB'(err_r) - IB'(prev_err_r); mul_b = gd_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= MODE_AUTO;
      target_r   <= 7'd55;
      gp_r       <= 16'd8192;
      gi_r       <= 16'd614;
      gd_r       <= 16'd1536;
      ctemp_r    <= 16'd17945;
      cpwm_r     <= 16'd51200;
      last_pwm_r <= 8'd0;
      isum_r     <= '0;
      prev_err_r <= '0;
      primed_r   <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: begin
            mode_r   <= cfg_data[2:0];
            primed_r <= 1'b0;
            if (cfg_data[2:0] == MODE_PID) begin
              isum_r <= '0; prev_err_r <= '0;
            end else if (cfg_data[2:0] == MODE_FULL) last_pwm_r <= PWM_MAX;
            else if (cfg_data[2:0] == MODE_OFF)     last_pwm_r <= 8'd0;
          end
          REG_TARGET: target_r <= cfg_data[6:0];
          REG_GP:     gp_r     <= cfg_data;
          REG_GI:     gi_r     <= cfg_data;
          REG_GD:     gd_r     <= cfg_data;
          REG_CTEMP:  ctemp_r  <= cfg_data;
          REG_CPWM:   cpwm_r   <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          temp_r  <= $signed(in_tdata[7:0]);
          stop_r  <= in_tdata[14:8];
          force_r <= in_tdata[15];
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          state_r <= S_OUT;
          if (mode_r == MODE_OFF) begin
            res_pwm_r <= 8'd0; res_by_r <= BY_DISABLED;
          end else if (force_r) begin
            res_pwm_r <= PWM_MAX; res_by_r <= BY_OVERRIDE;
          end else if (temp_r == -8'sd1) begin
            res_pwm_r <= last_pwm_r; res_by_r <= BY_HELD;
          end else if (stop_r != 7'd0 && t9 >= stop_m) begin
            res_pwm_r <= PWM_MAX; res_by_r <= BY_SAFETY;
          end else if (mode_r == MODE_FULL) begin
            res_pwm_r <= PWM_MAX; res_by_r <= BY_FULL;
          end else if (mode_r == MODE_PID) begin
            res_by_r <= BY_PID;
            err_r    <= err_c;
            if (!primed_r) begin
              prev_err_r <= err_c; primed_r <= 1'b1;
            end
            state_r <= S_MP;
          end else begin
            res_by_r <= BY_CURVE;
            if (mode_r == MODE_NORMAL) res_pwm_r <= normal_lut(k_idx);
            else if (mode_r == MODE_AGGR) res_pwm_r <= aggr_lut(k_idx);
            else state_r <= S_LIN_MUL;
          end
        end
        S_MP: begin acc_r <= AW'(mul_p); state_r <= S_MI; end
        S_MI: begin
          acc_r <= acc_r + AW'(mul_p); inew_r <= isum_sat; state_r <= S_MD;
        end
        S_MD: begin acc_r <= acc_r + AW'(mul_p); state_r <= S_PIDEND; end
        S_PIDEND: begin
          if (acc_r > AW'(255 * 1024)) res_pwm_r <= PWM_MAX;
          else if (acc_r < 0)         res_pwm_r <= 8'd0;
          else begin
            res_pwm_r <= 8'((acc_r + AW'(512)) >>> 10);
            isum_r    <= inew_r;
          end
          prev_err_r <= err_r;
          state_r    <= S_OUT;
        end
        S_LIN_MUL: begin
          pmin_r  <= c_pmin;
          num_r   <= lin_num;
          den_r   <= (mode_r == MODE_SILENT) ? 9'd0 : 9'(tmax9 - 9'(c_tmin));
          rem_r   <= '0;
          cnt_r   <= 5'd16;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // silent divides by 625, held apart since it exceeds 9 bits
          if (mode_r == MODE_SILENT) begin
            if (rem_sh >= 17'd625) begin
              rem_r <= 16'(rem_sh - 17'd625); num_r <= {num_r[14:0], 1'b1};
            end else begin
              rem_r <= rem_sh[15:0]; num_r <= {num_r[14:0], 1'b0};
            end
          end else if (rem_sh >= 17'(den_r)) begin
            rem_r <= 16'(rem_sh - 17'(den_r)); num_r <= {num_r[14:0], 1'b1};
          end else begin
            rem_r <= rem_sh[15:0]; num_r <= {num_r[14:0], 1'b0};
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) state_r <= S_DIVEND;
        end
        S_DIVEND: begin res_pwm_r <= 8'(pmin_r + num_r[7:0]); state_r <= S_OUT; end
        S_OUT: if (!ovalid_r) begin
          opwm_r   <= res_pwm_r;
          oby_r    <= res_by_r;
          ovalid_r <= 1'b1;
          if (res_by_r != BY_HELD) last_pwm_r <= res_pwm_r;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a held result repeats the last pwm
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !ovalid_r && res_by_r == BY_HELD) |=> opwm_r == last_pwm_r)
    else $error("held pwm mismatch");
  // disabled results always carry zero pwm
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && oby_r == BY_DISABLED) |-> opwm_r == 8'd0)
    else $error("disabled pwm nonzero");
  // no new input while a transaction is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("ready while busy");
endmodule
